// File: sv/sdik_pkg.sv
// Package for swerve drive inverse kinematics: widths, constants, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdik_pkg;
    localparam int VelW   = 24;
    localparam int CfgW   = 23;
    localparam int AngW   = 20;
    localparam int AgeW   = 16;
    localparam int SpdW   = 32;
    localparam int CorW   = 34;   // corner term width
    localparam int SqW    = 70;   // p^2 + q^2
    localparam int HypW   = 35;
    localparam int CorSteps = 17;
    localparam int SqrtSteps = 35;
    localparam int CwW    = 40;   // CORDIC x/y width
    localparam int ZW     = 20;
    localparam logic signed [ZW-1:0] PiQ     = 20'sd205887;
    localparam logic signed [ZW-1:0] HalfPiQ = 20'sd102944;
    localparam int DeadbandQ = 65;
    localparam int AddrW = 5;

    // register reset values
    localparam logic [CfgW-1:0]        RstAxleSpan   = 23'd16384;
    localparam logic [CfgW-1:0]        RstSteerTrack = 23'd16384;
    localparam logic [CfgW-1:0]        RstInvRadius  = 23'd655360;
    localparam logic signed [AngW-1:0] RstMinAngle   = -20'sd205887;
    localparam logic signed [AngW-1:0] RstMaxAngle   = 20'sd205887;
    localparam logic [AgeW-1:0]        RstTimeout    = 16'd500;

    typedef enum logic [1:0] {
        ST_DRIVE = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_LIMIT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_AXLE_SPAN = 3'd0,
        REG_STEER_TRACK = 3'd1,
        REG_INV_RADIUS = 3'd2,
        REG_MIN_ANGLE = 3'd3,
        REG_MAX_ANGLE = 3'd4,
        REG_TIMEOUT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CfgW-1:0]        axle_span;
        logic [CfgW-1:0]        steer_track;
        logic [CfgW-1:0]        inv_radius;
        logic signed [AngW-1:0] min_angle;
        logic signed [AngW-1:0] max_angle;
        logic [AgeW-1:0]        timeout;
    } t_cfg;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0: r = 20'sd51472;
            5'd1: r = 20'sd30385;
            5'd2: r = 20'sd16055;
            5'd3: r = 20'sd8150;
            5'd4: r = 20'sd4091;
            5'd5: r = 20'sd2047;
            5'd6: r = 20'sd1024;
            5'd7: r = 20'sd512;
            5'd8: r = 20'sd256;
            5'd9: r = 20'sd128;
            5'd10: r = 20'sd64;
            5'd11: r = 20'sd32;
            5'd12: r = 20'sd16;
            5'd13: r = 20'sd8;
            5'd14: r = 20'sd4;
            5'd15: r = 20'sd2;
            5'd16: r = 20'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// File: sv/sdik_if.sv
// Valid/ready channel interfaces for command and wheel result.
// Depends on sdik_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface sdik_cmd_if;
    import sdik_pkg::*;
    logic valid;
    logic ready;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] yaw_rate;
    logic [AgeW-1:0] cmd_age;
    modport source (output valid, vel_x, vel_y, yaw_rate, cmd_age, input ready);
    modport sink (input valid, vel_x, vel_y, yaw_rate, cmd_age, output ready);
endinterface

interface sdik_res_if;
    import sdik_pkg::*;
    logic valid;
    logic ready;
    logic signed [SpdW-1:0] front_left_speed;
    logic signed [SpdW-1:0] front_right_speed;
    logic signed [SpdW-1:0] rear_left_speed;
    logic signed [SpdW-1:0] rear_right_speed;
    logic signed [AngW-1:0] front_left_angle;
    logic signed [AngW-1:0] front_right_angle;
    logic signed [AngW-1:0] rear_left_angle;
    logic signed [AngW-1:0] rear_right_angle;
    logic [1:0] drive_status;
    logic angles_valid;
    modport source (output valid, front_left_speed, front_right_speed, rear_left_speed,
        rear_right_speed, front_left_angle, front_right_angle, rear_left_angle,
        rear_right_angle, drive_status, angles_valid, input ready);
    modport sink (input valid, front_left_speed, front_right_speed, rear_left_speed,
        rear_right_speed, front_left_angle, front_right_angle, rear_left_angle,
        rear_right_angle, drive_status, angles_valid, output ready);
endinterface
`default_nettype wire

// File: sv/sdik_cordic.sv
// Pipelined CORDIC vectoring atan2, one step per stage, with axis bypass.
// Depends on sdik_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdik_cordic (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire logic signed [sdik_pkg::CorW-1:0] i_p,
    input  wire logic signed [sdik_pkg::CorW-1:0] i_q,
    output logic signed [sdik_pkg::ZW-1:0] o_angle
);
    import sdik_pkg::*;
    localparam int N = CorSteps + 1;
    logic signed [CwW-1:0] r_x [N];
    logic signed [CwW-1:0] r_y [N];
    logic signed [ZW+1:0]  r_z [N];
    logic                  r_byp [N];
    logic signed [ZW-1:0]  r_bz [N];
    logic signed [ZW+1:0]  w_zc;

    // stage 0: axis cases and pre-rotation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byp[0] <= (i_p == 0) || (i_q == 0);
            if (i_p == 0)
                r_bz[0] <= (i_q >= 0) ? '0 : PiQ;
            else
                r_bz[0] <= (i_p > 0) ? HalfPiQ : -HalfPiQ;
            if (i_q < 0) begin
                if (i_p >= 0) begin
                    r_x[0] <= CwW'(i_p); r_y[0] <= -CwW'(i_q); r_z[0] <= 22'(HalfPiQ);
                end else begin
                    r_x[0] <= -CwW'(i_p); r_y[0] <= CwW'(i_q); r_z[0] <= -22'(HalfPiQ);
                end
            end else begin
                r_x[0] <= CwW'(i_q); r_y[0] <= CwW'(i_p); r_z[0] <= '0;
            end
        end
    end

    for (genvar s = 0; s < CorSteps; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_byp[s+1] <= r_byp[s];
                r_bz[s+1] <= r_bz[s];
                if (r_y[s] > 0) begin
                    r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                    r_z[s+1] <= r_z[s] + 22'(atan_lut(5'(s)));
                end else begin
                    r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                    r_z[s+1] <= r_z[s] - 22'(atan_lut(5'(s)));
                end
            end
        end
    end

    always_comb begin
        w_zc = r_z[N-1];
        if (w_zc > 22'(PiQ)) w_zc = 22'(PiQ);
        if (w_zc < -22'(PiQ)) w_zc = -22'(PiQ);
        o_angle = r_byp[N-1] ? r_bz[N-1] : ZW'(w_zc);
    end
endmodule
`default_nettype wire

// File: sv/sdik_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
// Depends on sdik_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdik_sqrt (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire logic [sdik_pkg::SqW-1:0] i_v,
    output logic [sdik_pkg::HypW-1:0] o_root
);
    import sdik_pkg::*;
    localparam int N = SqrtSteps;
    logic [SqW-1:0]  r_rem [N+1];
    logic [HypW-1:0] r_root [N+1];
    logic [SqW-1:0]  w_trial [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_v;
            r_root[0] <= '0;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_bit
        localparam int B = N - 1 - s;
        // trial = (2*root*2^B + 2^(2B)), root holds bits above B
        assign w_trial[s] = (SqW'(r_root[s]) << (B + 1)) | (SqW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[s] >= w_trial[s]) begin
                    r_rem[s+1] <= r_rem[s] - w_trial[s];
                    r_root[s+1] <= r_root[s] | (HypW'(1) << B);
                end else begin
                    r_rem[s+1] <= r_rem[s];
                    r_root[s+1] <= r_root[s];
                end
            end
        end
    end
    assign o_root = r_root[N];
endmodule
`default_nettype wire

// File: sv/sdik_wheel.sv
// One wheel: squared magnitude, square root, atan2 and speed scaling, aligned.
// Depends on sdik_pkg, sdik_sqrt, sdik_cordic.
`timescale 1ns / 1ps
`default_nettype none
module sdik_wheel (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire logic signed [sdik_pkg::CorW-1:0] i_p,
    input  wire logic signed [sdik_pkg::CorW-1:0] i_q,
    input  wire logic [sdik_pkg::CfgW-1:0] i_inv_radius,
    output logic signed [sdik_pkg::SpdW:0] o_speed,
    output logic signed [sdik_pkg::ZW-1:0] o_angle
);
    import sdik_pkg::*;
    // speed path registers: square, add, sqrt input and bit stages, multiply; saturation is combinational
    // angle path: cordic, then a delay line to match the speed path
    localparam int SpdLat = 2 + SqrtSteps + 1 + 1;
    localparam int AngDly = SpdLat - (CorSteps + 1);
    // corner terms stay below 2^31 in magnitude
    logic [SpdW-1:0] w_pp, w_qq;
    logic [2*SpdW-1:0] w_pp2, w_qq2;
    logic [SqW-1:0] r_p2, r_q2, r_sum;
    logic [HypW-1:0] w_root;
    logic [HypW+CfgW-1:0] r_prod;
    logic signed [ZW-1:0] w_ang;
    logic signed [ZW-1:0] r_adly [AngDly];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2 <= SqW'(w_pp2);
            r_q2 <= SqW'(w_qq2);
            r_sum <= r_p2 + r_q2;
        end
    end
    always_comb begin
        w_pp = (i_p < 0) ? SpdW'(-i_p) : SpdW'(i_p);
        w_qq = (i_q < 0) ? SpdW'(-i_q) : SpdW'(i_q);
        w_pp2 = w_pp * w_pp;
        w_qq2 = w_qq * w_qq;
    end

    sdik_sqrt u_sqrt (.i_clk(i_clk), .i_en(i_en), .i_v(r_sum), .o_root(w_root));

    always_ff @(posedge i_clk) begin
        if (i_en) r_prod <= (HypW+CfgW)'(w_root) * (HypW+CfgW)'(i_inv_radius);
    end
    always_comb begin
        if ((r_prod >> 16) > (HypW+CfgW)'(32'h7FFF_FFFF))
            o_speed = 33'sh0_7FFF_FFFF;
        else
            o_speed = $signed({1'b0, r_prod[47:16]});
    end

    sdik_cordic u_cordic (.i_clk(i_clk), .i_en(i_en), .i_p(i_p), .i_q(i_q), .o_angle(w_ang));
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_adly[0] <= w_ang;
            for (int k = 1; k < AngDly; k++) r_adly[k] <= r_adly[k-1];
        end
    end
    assign o_angle = r_adly[AngDly-1];
endmodule
`default_nettype wire

// File: sv/swerve_drive_inverse_kinematics_top.sv
// Swerve drive inverse kinematics top: config port, corner terms, wheels, limits.
// Pipeline: 41 register stages; the 35-step square root sets the depth.
// Throughput one request per cycle while the output is not stalled.
// The whole pipeline advances together; a stalled output freezes it (no loss).
// Reset (synchronous, active low) clears valid bits and loads register defaults.
// Depends on sdik_pkg, sdik_if, sdik_wheel.
`timescale 1ns / 1ps
`default_nettype none
module swerve_drive_inverse_kinematics_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sdik_cmd_if.sink   i_cmd,
    sdik_res_if.source o_res,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [sdik_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import sdik_pkg::*;
    localparam int WLat = 2 + SqrtSteps + 2;  // wheel unit depth
    localparam int Depth = 1 + WLat + 1;      // corner stage, wheels, limit stage

    t_cfg r_cfg;
    logic w_en;
    logic [Depth-1:0] r_vld;
    t_reg_idx w_idx;

    // configuration port
    assign pready = 1'b1;
    assign w_idx = t_reg_idx'(paddr[4:2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axle_span <= RstAxleSpan;
            r_cfg.steer_track <= RstSteerTrack;
            r_cfg.inv_radius <= RstInvRadius;
            r_cfg.min_angle <= RstMinAngle;
            r_cfg.max_angle <= RstMaxAngle;
            r_cfg.timeout <= RstTimeout;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (w_idx)
                REG_AXLE_SPAN: r_cfg.axle_span <= pwdata[CfgW-1:0];
                REG_STEER_TRACK: r_cfg.steer_track <= pwdata[CfgW-1:0];
                REG_INV_RADIUS: r_cfg.inv_radius <= pwdata[CfgW-1:0];
                REG_MIN_ANGLE: r_cfg.min_angle <= pwdata[AngW-1:0];
                REG_MAX_ANGLE: r_cfg.max_angle <= pwdata[AngW-1:0];
                REG_TIMEOUT: r_cfg.timeout <= pwdata[AgeW-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (w_idx)
                REG_AXLE_SPAN: prdata = 32'(r_cfg.axle_span);
                REG_STEER_TRACK: prdata = 32'(r_cfg.steer_track);
                REG_INV_RADIUS: prdata = 32'(r_cfg.inv_radius);
                REG_MIN_ANGLE: prdata = 32'(signed'(r_cfg.min_angle));
                REG_MAX_ANGLE: prdata = 32'(signed'(r_cfg.max_angle));
                REG_TIMEOUT: prdata = 32'(r_cfg.timeout);
                default: prdata = '0;
            endcase
        end
    end

    // pipeline advances when output is free or empty
    assign w_en = o_res.ready || !r_vld[Depth-1];
    assign i_cmd.ready = w_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[Depth-2:0], i_cmd.valid};
    end

    // stage 1: corner terms, timeout and deadband flags
    logic signed [CorW-1:0] r_a, r_b, r_c, r_d;
    logic r_tmo, r_act;
    logic signed [48:0] w_wl, w_wt;
    function automatic logic signed [CorW-1:0] rnd(input logic signed [48:0] t);
        logic signed [48:0] u;
        u = t + 49'sd32768;
        return CorW'(u >>> 16);
    endfunction
    function automatic logic dbo(input logic signed [VelW-1:0] v);
        return (v > 24'sd65) || (v < -24'sd65);
    endfunction
    assign w_wl = 49'(i_cmd.yaw_rate) * $signed({26'd0, r_cfg.axle_span});
    assign w_wt = 49'(i_cmd.yaw_rate) * $signed({26'd0, r_cfg.steer_track});
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= rnd((49'(i_cmd.vel_y) <<< 16) - w_wl);
            r_b <= rnd((49'(i_cmd.vel_y) <<< 16) + w_wl);
            r_c <= rnd((49'(i_cmd.vel_x) <<< 16) - w_wt);
            r_d <= rnd((49'(i_cmd.vel_x) <<< 16) + w_wt);
            r_tmo <= i_cmd.cmd_age > r_cfg.timeout;
            r_act <= dbo(i_cmd.vel_x) || dbo(i_cmd.vel_y) || dbo(i_cmd.yaw_rate);
        end
    end

    logic r_tmo_d [WLat];
    logic r_act_d [WLat];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tmo_d[0] <= r_tmo; r_act_d[0] <= r_act;
            for (int k = 1; k < WLat; k++) begin
                r_tmo_d[k] <= r_tmo_d[k-1]; r_act_d[k] <= r_act_d[k-1];
            end
        end
    end

    logic signed [SpdW:0] w_spd [4];
    logic signed [ZW-1:0] w_ang [4];
    logic signed [CorW-1:0] w_p [4];
    logic signed [CorW-1:0] w_q [4];
    assign w_p[0] = r_b; assign w_q[0] = r_c;
    assign w_p[1] = r_b; assign w_q[1] = r_d;
    assign w_p[2] = r_a; assign w_q[2] = r_c;
    assign w_p[3] = r_a; assign w_q[3] = r_d;
    for (genvar k = 0; k < 4; k++) begin : g_wheel
        sdik_wheel u_wheel (.i_clk(i_clk), .i_en(w_en), .i_p(w_p[k]), .i_q(w_q[k]),
            .i_inv_radius(r_cfg.inv_radius), .o_speed(w_spd[k]), .o_angle(w_ang[k]));
    end

    // limit stage
    logic signed [SpdW-1:0] n_spd [4];
    logic signed [AngW-1:0] n_ang [4];
    logic n_fail;
    logic signed [AngW:0] w_a, w_mn, w_mx;
    logic signed [SpdW:0] w_s;
    always_comb begin
        n_fail = 1'b0;
        w_mn = 21'(r_cfg.min_angle);
        w_mx = 21'(r_cfg.max_angle);
        for (int k = 0; k < 4; k++) begin
            w_a = r_act_d[WLat-1] ? 21'(w_ang[k]) : '0;
            w_s = r_act_d[WLat-1] ? w_spd[k] : '0;
            if (w_a > w_mx) begin
                if (w_a - 21'(PiQ) > w_mn) begin
                    w_a = w_a - 21'(PiQ); w_s = -w_s;
                end else n_fail = 1'b1;
            end else if (w_a < w_mn) begin
                if (w_a + 21'(PiQ) < w_mx) begin
                    w_a = w_a + 21'(PiQ); w_s = -w_s;
                end else n_fail = 1'b1;
            end
            n_spd[k] = SpdW'(w_s);
            n_ang[k] = AngW'(w_a);
        end
    end

    logic signed [SpdW-1:0] r_spd [4];
    logic signed [AngW-1:0] r_ang [4];
    t_status r_st;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            priority if (r_tmo_d[WLat-1]) r_st <= ST_TIMEOUT;
            else if (n_fail) r_st <= ST_LIMIT;
            else r_st <= ST_DRIVE;
            for (int k = 0; k < 4; k++) begin
                r_spd[k] <= (r_tmo_d[WLat-1] || n_fail) ? '0 : n_spd[k];
                r_ang[k] <= (r_tmo_d[WLat-1] || n_fail) ? '0 : n_ang[k];
            end
        end
    end

    assign o_res.valid = r_vld[Depth-1];
    assign o_res.front_left_speed = r_spd[0];
    assign o_res.front_right_speed = r_spd[1];
    assign o_res.rear_left_speed = r_spd[2];
    assign o_res.rear_right_speed = r_spd[3];
    assign o_res.front_left_angle = r_ang[0];
    assign o_res.front_right_angle = r_ang[1];
    assign o_res.rear_left_angle = r_ang[2];
    assign o_res.rear_right_angle = r_ang[3];
    assign o_res.drive_status = r_st;
    assign o_res.angles_valid = (r_st == ST_DRIVE);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.drive_status != 2'd3)) else $error("bad status");
    a_brake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.angles_valid) |-> (o_res.front_left_speed == 0))
        else $error("brake speed not zero");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> o_res.valid) else $error("result dropped");
endmodule
`default_nettype wire
